@@ sv/tcp_syn_probe_field_extractor_assert.svh @@
// Assertion macros shared by the extractor's RTL files.
// Each macro expects a signal named clk in the enclosing module; TSP_ASSERT also expects rst_n.
`ifndef TCP_SYN_PROBE_FIELD_EXTRACTOR_ASSERT_SVH
`define TCP_SYN_PROBE_FIELD_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked at every edge outside reset.
`define TSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define TSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TSP_ASSERT(label, prop, msg)
`define TSP_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ sv/tsp_pkg.sv @@
// Types, codes and constants of the TCP SYN probe field extractor.
// No dependencies; used by every RTL module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tsp_pkg;

    // Link type register codes.
    localparam logic [1:0] LINK_ETH    = 2'd0;
    localparam logic [1:0] LINK_WIFI   = 2'd1;
    localparam logic [1:0] LINK_COOKED = 2'd2;

    // Link header lengths in bytes.
    localparam logic [4:0] ETH_LEN    = 5'd14;
    localparam logic [4:0] WIFI_LEN   = 5'd24;
    localparam logic [4:0] COOKED_LEN = 5'd16;

    localparam int MIN_FRAME     = 44;
    localparam int TCP_BASE_LEN  = 20;
    localparam int TS_MIN_LEFT   = 10;
    localparam int TSVAL_BYTES   = 4;

    // TCP option kinds.
    localparam logic [7:0] OPT_EOL = 8'd0;
    localparam logic [7:0] OPT_NOP = 8'd1;
    localparam logic [7:0] OPT_TS  = 8'd8;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    typedef enum logic [5:0] {
        PH_KIND  = 6'b000001,
        PH_LEN   = 6'b000010,
        PH_SKIP  = 6'b000100,
        PH_TSLEN = 6'b001000,
        PH_TSVAL = 6'b010000,
        PH_DONE  = 6'b100000
    } opt_phase_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] source_address;
        logic [31:0] sequence_number;
        logic [31:0] timestamp_value;
    } tsp_result_t;

    function automatic logic [4:0] link_len(input logic [1:0] kind);
        logic [4:0] len;
        case (kind)
            LINK_WIFI:   len = WIFI_LEN;
            LINK_COOKED: len = COOKED_LEN;
            default:     len = ETH_LEN;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ sv/tsp_parser.sv @@
// Byte parser: input register, header field collectors and TCP option walk,
// with the result formed at the frame's last byte. Depends on tsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsp_parser
    import tsp_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  frame_byte,
    input  wire logic        frame_last,
    input  wire logic [1:0]  link_type,
    output logic             pending,
    output logic             res_valid,
    output tsp_result_t      res
);

    `include "tcp_syn_probe_field_extractor_assert.svh"

    localparam int XW = POSITION_BITS + 1;

    logic                     byte_valid_reg;
    logic [7:0]               byte_reg;
    logic                     last_reg;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [3:0]               ihl_reg, ihl_next;
    logic [3:0]               thl_reg, thl_next;
    logic [31:0]              src_reg, src_next;
    logic [31:0]              seq_reg, seq_next;
    logic [31:0]              ts_reg, ts_next;
    opt_phase_t               phase_reg, phase_next;
    logic [5:0]               left_reg, left_next;
    logic [7:0]               skip_reg, skip_next;
    logic                     found_reg, found_next;

    logic                     active;
    logic [XW-1:0]            pos_x;
    logic [XW-1:0]            lh_x;
    logic [XW-1:0]            t_x;
    logic [XW-1:0]            caplen;
    logic                     at_offset;
    logic                     in_opts;

    // Input register: the accepted word is parsed in the following cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= frame_byte;
            last_reg <= frame_last;
        end
    end

    assign pending = byte_valid_reg & last_reg;

    always_comb
    begin
        active = byte_valid_reg && (pos_reg != {POSITION_BITS{1'b1}});
        pos_x  = {1'b0, pos_reg};
        lh_x   = XW'(link_len(link_type));

        ihl_next = (active && pos_x == lh_x) ? byte_reg[3:0] : ihl_reg;
        t_x      = lh_x + XW'({ihl_next, 2'b00});

        src_next = src_reg;
        if (active && pos_x >= lh_x + XW'(12) && pos_x <= lh_x + XW'(15))
        begin
            src_next = {src_reg[23:0], byte_reg};
        end

        seq_next = seq_reg;
        if (active && pos_x >= t_x + XW'(4) && pos_x <= t_x + XW'(7))
        begin
            seq_next = {seq_reg[23:0], byte_reg};
        end

        thl_next   = thl_reg;
        left_next  = left_reg;
        phase_next = phase_reg;
        skip_next  = skip_reg;
        ts_next    = ts_reg;
        found_next = found_reg;

        at_offset = active && (pos_x == t_x + XW'(12));
        in_opts   = active && (pos_x >= t_x + XW'(TCP_BASE_LEN)) && (phase_reg != PH_DONE);

        if (at_offset)
        begin
            thl_next = byte_reg[7:4];
            if (byte_reg[7:4] >= 4'd5)
            begin
                left_next = {byte_reg[7:4], 2'b00} - 6'(TCP_BASE_LEN);
            end
            else
            begin
                left_next = 6'd0;
            end
            phase_next = (left_next != 6'd0) ? PH_KIND : PH_DONE;
        end
        else if (in_opts)
        begin
            case (phase_reg)
                PH_KIND:
                begin
                    if (left_reg == 6'd0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (byte_reg == OPT_NOP)
                    begin
                        left_next = left_reg - 6'd1;
                    end
                    else if (byte_reg == OPT_TS)
                    begin
                        phase_next = (left_reg < 6'(TS_MIN_LEFT)) ? PH_DONE : PH_TSLEN;
                    end
                    else if (byte_reg == OPT_EOL || left_reg < 6'd2)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (byte_reg < 8'd2 || byte_reg > {2'b00, left_reg})
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        left_next  = left_reg - byte_reg[5:0];
                        skip_next  = byte_reg - 8'd2;
                        phase_next = (byte_reg != 8'd2) ? PH_SKIP : PH_KIND;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 8'd1;
                    if (skip_next == 8'd0)
                    begin
                        phase_next = PH_KIND;
                    end
                end
                PH_TSLEN:
                begin
                    skip_next  = 8'(TSVAL_BYTES);
                    phase_next = PH_TSVAL;
                end
                PH_TSVAL:
                begin
                    ts_next   = {ts_reg[23:0], byte_reg};
                    skip_next = skip_reg - 8'd1;
                    if (skip_next == 8'd0)
                    begin
                        found_next = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        pos_next = active ? pos_reg + POSITION_BITS'(1) : pos_reg;
    end

    // Result for the frame's last word, built from the updated collectors.
    always_comb
    begin
        caplen    = pos_x + XW'(1);
        res_valid = byte_valid_reg & last_reg;
        res       = '0;
        if (caplen < XW'(MIN_FRAME))
        begin
            res.status = ST_SHORT;
        end
        else if (caplen < t_x + XW'(TCP_BASE_LEN))
        begin
            res.status         = ST_TRUNC;
            res.source_address = src_next;
        end
        else
        begin
            res.status          = ST_OK;
            res.source_address  = src_next;
            res.sequence_number = seq_next;
            if (found_next && caplen > t_x + XW'(TCP_BASE_LEN) &&
                caplen >= t_x + XW'({thl_next, 2'b00}))
            begin
                res.timestamp_value = ts_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            ihl_reg   <= '0;
            thl_reg   <= '0;
            src_reg   <= '0;
            seq_reg   <= '0;
            ts_reg    <= '0;
            phase_reg <= PH_KIND;
            left_reg  <= '0;
            skip_reg  <= '0;
            found_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            // The frame is finished: all per-frame state starts afresh.
            pos_reg   <= '0;
            ihl_reg   <= '0;
            thl_reg   <= '0;
            src_reg   <= '0;
            seq_reg   <= '0;
            ts_reg    <= '0;
            phase_reg <= PH_KIND;
            left_reg  <= '0;
            skip_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            ihl_reg   <= ihl_next;
            thl_reg   <= thl_next;
            src_reg   <= src_next;
            seq_reg   <= seq_next;
            ts_reg    <= ts_next;
            phase_reg <= phase_next;
            left_reg  <= left_next;
            skip_reg  <= skip_next;
            found_reg <= found_next;
        end
    end

    `TSP_ASSERT(a_left_bounded, left_reg <= 6'd40, "option bytes left exceed the TCP option space")
    `TSP_ASSERT(a_found_done, found_reg |-> phase_reg == PH_DONE, "timestamp found but walk not finished")
    `TSP_ASSERT(a_short_zero, (res_valid && res.status == ST_SHORT) |-> (res.source_address == 32'd0 && res.sequence_number == 32'd0 && res.timestamp_value == 32'd0), "short frame result carries fields")

endmodule

`default_nettype wire

@@ sv/tsp_out_buf.sv @@
// Two-entry result buffer: result register plus skid entry, and the input
// stall that keeps it from overflowing. Depends on tsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsp_out_buf
    import tsp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  tsp_result_t      push_res,
    input  wire logic        pending,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    output tsp_result_t      out_res
);

    `include "tcp_syn_probe_field_extractor_assert.svh"

    logic        head_valid_reg;
    logic        skid_valid_reg;
    tsp_result_t head_reg;
    tsp_result_t skid_reg;
    logic        pop;
    logic [1:0]  load;

    assign pop = head_valid_reg & ~out_stall;

    // Entries held next cycle if a word were taken now, counting the one
    // still in the input register.
    always_comb
    begin
        load = {1'b0, head_valid_reg} + {1'b0, skid_valid_reg} + {1'b0, pending}
               - {1'b0, pop};
        in_stall = load[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                if (!head_valid_reg || (pop && !skid_valid_reg))
                begin
                    head_valid_reg <= 1'b1;
                end
                else if (!pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                head_valid_reg <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            if (!head_valid_reg || (pop && !skid_valid_reg))
            begin
                head_reg <= push_res;
            end
            else if (pop)
            begin
                head_reg <= skid_reg;
                skid_reg <= push_res;
            end
            else
            begin
                skid_reg <= push_res;
            end
        end
        else if (pop)
        begin
            head_reg <= skid_reg;
        end
    end

    assign out_valid = head_valid_reg;
    assign out_res   = head_reg;

    `TSP_ASSERT(a_no_overflow, !(push && head_valid_reg && skid_valid_reg && !pop), "result buffer overflow")
    `TSP_ASSERT(a_skid_behind_head, skid_valid_reg |-> head_valid_reg, "skid entry held without a result")
    `TSP_ASSERT(a_full_stalls, (skid_valid_reg && !pop) |-> in_stall, "input open while buffer is full")

endmodule

`default_nettype wire

@@ sv/tcp_syn_probe_field_extractor.sv @@
// Extracts source address, sequence number and TCP timestamp from a frame.
// A captured frame enters one byte per word on the input channel; frame_last
// marks its final byte. The link header length follows cfg_data (link_type):
// Ethernet 14, 802.11 24, cooked 16 bytes; code 3 acts as Ethernet.
// For each frame one result word leaves on the output channel with status,
// source_address, sequence_number and timestamp_value.
// Throughput: one byte per cycle while in_stall is low; the parser updates its
// collectors and option walk combinationally from the input register.
// Each result passes the input register, then the result register.
// When the receiver stalls, the result register and a skid entry hold up
// to two results; bytes keep flowing until a held result and the one in
// the input register would fill both, at which point in_stall rises.
// The configuration channel is always ready; the user must write it only while
// idle, which the block does not enforce. Reset sets link_type to Ethernet,
// clears all frame state and empties the result buffer.
`timescale 1ns / 1ps
`default_nettype none

module tcp_syn_probe_field_extractor
    import tsp_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  frame_byte,
    input  wire logic        frame_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [31:0]      source_address,
    output logic [31:0]      sequence_number,
    output logic [31:0]      timestamp_value
);

    logic [1:0]  link_type_reg;
    logic        accept;
    logic        pending;
    logic        res_valid;
    tsp_result_t res;
    tsp_result_t out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_type_reg <= LINK_ETH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            link_type_reg <= cfg_data;
        end
    end

    assign accept = in_valid & ~in_stall;

    tsp_parser #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_byte (frame_byte),
        .frame_last (frame_last),
        .link_type  (link_type_reg),
        .pending    (pending),
        .res_valid  (res_valid),
        .res        (res)
    );

    tsp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .pending   (pending),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign status          = out_res.status;
    assign source_address  = out_res.source_address;
    assign sequence_number = out_res.sequence_number;
    assign timestamp_value = out_res.timestamp_value;

endmodule

`default_nettype wire

@@ sim/tb_tcp_syn_probe_field_extractor.sv @@
// Self-checking testbench for tcp_syn_probe_field_extractor: sends captured frames byte by
// byte and checks every result word against a behavioural parser of its own.
// Depends on tsp_pkg and the extractor RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_tcp_syn_probe_field_extractor;
    import tsp_pkg::*;

    localparam int POS_BITS = 16;
    localparam longint POS_MAX = (64'd1 << POS_BITS) - 1;
    localparam int RANDOM_BYTES = 950;
    localparam int RANDOM_FRAMES = 60;
    localparam int FRAMES_PER_PHASE = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;

    // How the unused bytes of a frame are filled.
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO = 1;
    localparam int FILL_ONES = 2;

    // Further TCP option kinds used by the stimulus.
    localparam logic [7:0] OPT_MSS = 8'd2;
    localparam logic [7:0] OPT_WSCALE = 8'd3;
    localparam logic [7:0] OPT_SACK_OK = 8'd4;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [7:0] frame_byte;
    logic frame_last;
    logic out_valid;
    logic out_stall;
    logic [1:0] status;
    logic [31:0] source_address;
    logic [31:0] sequence_number;
    logic [31:0] timestamp_value;

    // Parser state mirrored by the testbench.
    logic [1:0] link_sel;
    longint byte_pos;
    logic [3:0] ip_words;
    logic [3:0] tcp_words;
    logic [31:0] src_acc;
    logic [31:0] seq_acc;
    logic [31:0] tsval_acc;
    opt_phase_t opt_ph;
    logic [5:0] opt_left;
    logic [7:0] skip_cnt;
    logic ts_found;

    tsp_result_t pending_results[$];
    logic [7:0] frame_buf[$];
    logic [7:0] opt_buf[$];

    int error_count = 0;
    int bytes_sent = 0;
    int hold_cycles = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    tcp_syn_probe_field_extractor #(
        .POSITION_BITS(POS_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .frame_byte(frame_byte),
        .frame_last(frame_last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .source_address(source_address),
        .sequence_number(sequence_number),
        .timestamp_value(timestamp_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] fill_byte(input int fill);
        logic [7:0] value;
        case (fill)
            FILL_ZERO: value = 8'h00;
            FILL_ONES: value = 8'hFF;
            default: value = rand_byte();
        endcase
        return value;
    endfunction

    function automatic int link_bytes();
        int len;
        case (link_sel)
            LINK_WIFI: len = WIFI_LEN;
            LINK_COOKED: len = COOKED_LEN;
            default: len = ETH_LEN;
        endcase
        return len;
    endfunction

    function automatic void clear_parser();
        byte_pos = 0;
        ip_words = '0;
        tcp_words = '0;
        src_acc = '0;
        seq_acc = '0;
        tsval_acc = '0;
        opt_ph = PH_KIND;
        opt_left = '0;
        skip_cnt = '0;
        ts_found = 1'b0;
    endfunction

    function automatic void step_option_walk(input logic [7:0] b);
        case (opt_ph)
            PH_KIND:
            begin
                if (opt_left == 0)
                    opt_ph = PH_DONE;
                else if (b == OPT_NOP)
                    opt_left = opt_left - 6'd1;
                else if (b == OPT_TS)
                    opt_ph = (opt_left < TS_MIN_LEFT) ? PH_DONE : PH_TSLEN;
                else if (b == OPT_EOL || opt_left < 2)
                    opt_ph = PH_DONE;
                else
                    opt_ph = PH_LEN;
            end
            PH_LEN:
            begin
                if (b < 2 || b > opt_left)
                    opt_ph = PH_DONE;
                else
                begin
                    opt_left = opt_left - 6'(b);
                    skip_cnt = b - 8'd2;
                    opt_ph = (skip_cnt != 0) ? PH_SKIP : PH_KIND;
                end
            end
            PH_SKIP:
            begin
                skip_cnt = skip_cnt - 8'd1;
                if (skip_cnt == 0)
                    opt_ph = PH_KIND;
            end
            PH_TSLEN:
            begin
                // The length byte of the timestamp option is taken on trust.
                skip_cnt = 8'(TSVAL_BYTES);
                opt_ph = PH_TSVAL;
            end
            PH_TSVAL:
            begin
                tsval_acc = {tsval_acc[23:0], b};
                skip_cnt = skip_cnt - 8'd1;
                if (skip_cnt == 0)
                begin
                    ts_found = 1'b1;
                    opt_ph = PH_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    // Advances the parser by one accepted byte and queues the result word that a
    // frame's last byte brings.
    function automatic void parse_byte(input logic [7:0] b, input logic last);
        longint p;
        longint lh;
        longint t;
        longint caplen;
        tsp_result_t r;
        p = byte_pos;
        lh = link_bytes();
        if (p < POS_MAX)
        begin
            if (p == lh)
                ip_words = b[3:0];
            if (p >= lh + 12 && p <= lh + 15)
                src_acc = {src_acc[23:0], b};
            t = lh + 4 * ip_words;
            if (p >= t + 4 && p <= t + 7)
                seq_acc = {seq_acc[23:0], b};
            if (p == t + 12)
            begin
                tcp_words = b[7:4];
                opt_left = (tcp_words >= 5) ? 6'(4 * tcp_words - 20) : 6'd0;
                opt_ph = (opt_left != 0) ? PH_KIND : PH_DONE;
            end
            if (p >= t + TCP_BASE_LEN && opt_ph != PH_DONE)
                step_option_walk(b);
            byte_pos = p + 1;
        end
        if (last)
        begin
            caplen = p + 1;
            t = lh + 4 * ip_words;
            r = '0;
            if (caplen < MIN_FRAME)
                r.status = ST_SHORT;
            else if (caplen < t + TCP_BASE_LEN)
            begin
                r.status = ST_TRUNC;
                r.source_address = src_acc;
            end
            else
            begin
                r.status = ST_OK;
                r.source_address = src_acc;
                r.sequence_number = seq_acc;
                if (ts_found && caplen - t > TCP_BASE_LEN && caplen >= t + 4 * tcp_words)
                    r.timestamp_value = tsval_acc;
            end
            pending_results.push_back(r);
            clear_parser();
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        tsp_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with none expected: status %0d", status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("source_address", want.source_address, source_address);
                check_field("sequence_number", want.sequence_number, sequence_number);
                check_field("timestamp_value", want.timestamp_value, timestamp_value);
            end
        end
    end

    // Receiver: a random stall before each result while rx_idle is set, plus an occasional long hold.
    initial
    begin : receiver
        int n;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            n = rx_idle ? $urandom_range(0, 7) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        #(5_000_000);
        $display("tcp_syn_probe_field_extractor: mismatch");
        $finish;
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        frame_byte <= value;
        frame_last <= last;
        do
            @(posedge clk);
        while (in_stall);
        parse_byte(value, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Drops the input, waits for every outstanding result word and lets the block settle.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_link(input logic [1:0] code);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= code;
        do
            @(posedge clk);
        while (!cfg_ready);
        link_sel = code;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Lays out a frame: the header-length nibbles and the option bytes go at the
    // places where the parser looks for them; the frame is cut at len bytes.
    function automatic void build_frame(input int lh, input int ihl, input int doff,
                                        input int len, input int fill);
        int t;
        int olen;
        int i;
        frame_buf.delete();
        for (i = 0; i < len; i++)
            frame_buf.push_back(fill_byte(fill));
        t = lh + 4 * ihl;
        olen = (doff >= 5) ? 4 * doff - 20 : 0;
        while (opt_buf.size() < olen)
            opt_buf.push_back(fill_byte(fill));
        if (lh < len)
            frame_buf[lh] = {frame_buf[lh][7:4], 4'(ihl)};
        if (t + 12 < len)
            frame_buf[t + 12] = {4'(doff), frame_buf[t + 12][3:0]};
        for (i = 0; i < olen; i++)
            if (t + 20 + i < len)
                frame_buf[t + 20 + i] = opt_buf[i];
        opt_buf.delete();
    endfunction

    task automatic send_built(input int ihl, input int doff, input int len);
        build_frame(link_bytes(), ihl, doff, len, FILL_RANDOM);
        send_frame();
    endtask

    function automatic void push_ts(input logic [7:0] len_byte, input int fill);
        int i;
        opt_buf.push_back(OPT_TS);
        opt_buf.push_back(len_byte);
        for (i = 0; i < 8; i++)
            opt_buf.push_back(fill_byte(fill));
    endfunction

    function automatic void random_options(input int olen);
        int i;
        int n;
        while (opt_buf.size() < olen)
        begin
            case ($urandom_range(0, 11))
                0, 1: opt_buf.push_back(OPT_NOP);
                2: opt_buf.push_back(($urandom_range(0, 3) == 0) ? OPT_EOL : OPT_NOP);
                3, 4, 5: push_ts(($urandom_range(0, 7) == 0) ? rand_byte() : 8'd10,
                                 FILL_RANDOM);
                6: opt_buf = {opt_buf, OPT_MSS, 8'd4, rand_byte(), rand_byte()};
                7: opt_buf = {opt_buf, OPT_WSCALE, 8'd3, rand_byte()};
                8: opt_buf = {opt_buf, OPT_SACK_OK, 8'd2};
                9: opt_buf = {opt_buf, 8'($urandom_range(2, 255)), 8'($urandom_range(0, 1))};
                default:
                begin
                    n = $urandom_range(2, ($urandom_range(0, 1) == 0) ? 10 : 44);
                    opt_buf = {opt_buf, rand_byte(), 8'(n)};
                    for (i = 0; i < n - 2; i++)
                        opt_buf.push_back(rand_byte());
                end
            endcase
        end
    endfunction

    // Mostly plausible SYN frames; now and then odd header lengths and cut-off frames.
    task automatic random_frame();
        int lh;
        int ihl;
        int doff;
        int hend;
        int len;
        int pick;
        lh = link_bytes();
        pick = $urandom_range(0, 15);
        ihl = (pick == 0) ? $urandom_range(0, 15) : (pick < 4) ? $urandom_range(6, 15) : 5;
        doff = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
        hend = lh + 4 * ihl + ((doff >= 5) ? 4 * doff : TCP_BASE_LEN);
        random_options((doff >= 5) ? 4 * doff - 20 : 0);
        pick = $urandom_range(0, 15);
        if (pick == 0)
            len = $urandom_range(1, MIN_FRAME - 1);
        else if (pick < 3)
            len = $urandom_range(MIN_FRAME, hend + 4);
        else
            len = hend + $urandom_range(0, 8);
        build_frame(lh, ihl, doff, len, FILL_RANDOM);
        send_frame();
    endtask

    task automatic test_short_frames();
        send_byte(rand_byte(), 1'b1);
        send_built(5, 5, 2);
        send_built(5, 5, MIN_FRAME - 1);
    endtask

    task automatic test_field_extremes();
        int lh;
        lh = link_bytes();
        build_frame(lh, 5, 5, 60, FILL_ZERO);
        send_frame();
        // All ones: the header-length nibble of 15 pushes the TCP header past the end.
        build_frame(lh, 15, 15, 60, FILL_ONES);
        send_frame();
        push_ts(8'hFF, FILL_ONES);
        build_frame(lh, 5, 15, lh + 20 + 60 + 2, FILL_ONES);
        send_frame();
    endtask

    task automatic test_option_walk();
        int t;
        t = link_bytes() + 20;
        // Timestamp met with exactly ten option bytes left.
        opt_buf = {OPT_NOP, OPT_NOP};
        push_ts(8'd10, FILL_RANDOM);
        send_built(5, 8, t + 34);
        opt_buf = {OPT_MSS, 8'd4, rand_byte(), rand_byte(), OPT_SACK_OK, 8'd2};
        push_ts(8'd10, FILL_RANDOM);
        opt_buf = {opt_buf, OPT_NOP, OPT_WSCALE, 8'd3, rand_byte()};
        send_built(5, 10, t + 40);
        // End of list ahead of the timestamp.
        opt_buf = {OPT_EOL};
        push_ts(8'd10, FILL_RANDOM);
        send_built(5, 8, t + 32);
        // Option lengths below two, and one longer than what is left.
        opt_buf = {OPT_WSCALE, 8'd1};
        push_ts(8'd10, FILL_RANDOM);
        send_built(5, 9, t + 36);
        opt_buf = {OPT_WSCALE, 8'd0};
        send_built(5, 8, t + 33);
        opt_buf = {OPT_MSS, 8'd30};
        send_built(5, 8, t + 32);
        // Timestamp with only eight option bytes left.
        opt_buf = {OPT_MSS, 8'd4, rand_byte(), rand_byte()};
        push_ts(8'd10, FILL_RANDOM);
        send_built(5, 8, t + 32);
        // Non-NOP kind with a single byte left.
        opt_buf = {OPT_NOP, OPT_NOP, OPT_NOP, OPT_MSS};
        send_built(5, 6, t + 26);
        // TCP header runs past the end although the timestamp is complete.
        opt_buf = {OPT_NOP, OPT_NOP};
        push_ts(8'd10, FILL_RANDOM);
        send_built(5, 10, t + 32);
        // Frame ends right at twenty bytes of TCP header.
        opt_buf = {OPT_NOP, OPT_NOP};
        push_ts(8'd10, FILL_RANDOM);
        send_built(5, 8, t + 20);
        send_built(5, 3, t + 30);
        opt_buf = {OPT_NOP, OPT_NOP};
        push_ts(8'd10, FILL_RANDOM);
        send_built(2, 8, t - 12 + 34);
        send_built(5, 5, MIN_FRAME);
        opt_buf = {OPT_NOP, OPT_NOP};
        push_ts(8'h33, FILL_RANDOM);
        send_built(5, 8, t + 33);
        opt_buf = {OPT_SACK_OK, 8'd2};
        push_ts(8'd10, FILL_RANDOM);
        send_built(5, 8, t + 32);
    endtask

    task automatic test_link_types();
        int code;
        for (code = 0; code < 4; code++)
        begin
            settle();
            write_link(2'(code));
            opt_buf = {OPT_NOP, OPT_NOP};
            push_ts(8'd10, FILL_RANDOM);
            send_built(5, 8, link_bytes() + 20 + 32 + 4);
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // words, so that the result buffer fills and the input stalls.
    task automatic test_backpressure();
        int lh;
        settle();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_cycles = HOLD_CYCLES;
        lh = link_bytes();
        repeat (10)
        begin
            build_frame(lh, 5, 5, lh + 40 + $urandom_range(0, 4), FILL_RANDOM);
            send_frame();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_pause_and_resume();
        repeat (3) random_frame();
        settle();
        repeat (3) random_frame();
    endtask

    // A frame long enough for the byte position to saturate.
    task automatic test_long_frame();
        settle();
        tx_idle = 1'b0;
        opt_buf = {OPT_NOP, OPT_NOP};
        push_ts(8'd10, FILL_RANDOM);
        build_frame(link_bytes(), 5, 8, int'(POS_MAX) + 5, FILL_RANDOM);
        send_frame();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_traffic();
        int frames;
        int first_byte;
        frames = 0;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES || frames < RANDOM_FRAMES)
        begin
            if (frames % FRAMES_PER_PHASE == 0)
            begin
                settle();
                write_link(2'($urandom_range(0, 3)));
                tx_idle = $urandom_range(0, 3) != 0;
                rx_idle = $urandom_range(0, 3) != 0;
            end
            random_frame();
            frames++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        frame_byte = '0;
        frame_last = 1'b0;
        link_sel = LINK_ETH;
        clear_parser();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_frames();
        test_field_extremes();
        test_option_walk();
        test_link_types();
        test_backpressure();
        test_pause_and_resume();
        test_long_frame();
        test_random_traffic();
        settle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("tcp_syn_probe_field_extractor: match");
        else
            $display("tcp_syn_probe_field_extractor: mismatch");
        $finish;
    end

endmodule
